// ===== rtl/rlbe_pkg.sv =====
`default_nettype none

package rlbe_pkg;

  // Segment limits and result packing
  localparam int MAX_SEGMENT      = 128;
  localparam int BYTES_PER_RESULT = 4;
  localparam int OUT_SLOTS        = 4;
  localparam int PACK_WIDTH       = (BYTES_PER_RESULT < 1) ? 1 :
                                    ((BYTES_PER_RESULT > OUT_SLOTS) ? OUT_SLOTS :
                                     BYTES_PER_RESULT);
  localparam int SLOT_AW          = $clog2(OUT_SLOTS);
  localparam int CNT_W            = 3;

  // Literal byte ring: room for one literal in flight and one filling
  localparam int RING_DEPTH = 2 * MAX_SEGMENT;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int LEN_W      = $clog2(MAX_SEGMENT + 1);

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One flush command: a closed segment, optionally followed by a single-byte tail
  typedef struct packed {
    logic [7:0]       hdr;
    logic [7:0]       val;
    logic             is_lit;
    logic [LEN_W-1:0] lit_len;
    logic             has_tail;
    logic [7:0]       tail_val;
    logic             blk_last;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/rlbe_ram.sv =====
`default_nettype none

module rlbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rlbe_front.sv =====
`default_nettype none

module rlbe_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         block_last,
  input  wire logic                         q_full,
  output logic                              cmd_push,
  output rlbe_pkg::cmd_t                    cmd,
  input  wire logic                         lit_read,
  output logic                              ram_we,
  output logic [rlbe_pkg::RING_AW-1:0]      ram_waddr,
  output logic [7:0]                        ram_wdata
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SINGLE,
    MODE_RUN,
    MODE_LITERAL
  } seg_mode_t;

  seg_mode_t                        mode, mode_next;
  logic [7:0]                       held, held_next;
  logic [rlbe_pkg::LEN_W-1:0]       seg_len, seg_len_next;
  logic [rlbe_pkg::RING_AW-1:0]     wr_ptr;
  logic [rlbe_pkg::FILL_W-1:0]      fill;
  logic [1:0]                       commit;
  logic                             accept;
  logic                             close;
  seg_mode_t                        flush_mode;
  logic [7:0]                       flush_val;
  logic [rlbe_pkg::LEN_W-1:0]       flush_len;

  // Stall on a full queue or when the ring has fewer than two free slots
  assign full   = q_full ||
                  (fill > rlbe_pkg::FILL_W'(rlbe_pkg::RING_DEPTH - 2));
  assign accept = push && !full;

  // Classify the byte against the open segment
  always_comb begin
    mode_next    = mode;
    held_next    = held;
    seg_len_next = seg_len;
    commit       = 2'd0;
    close        = 1'b0;
    ram_we       = accept;
    ram_waddr    = wr_ptr;
    ram_wdata    = data_byte;
    case (mode)
      MODE_IDLE: begin
        mode_next    = MODE_SINGLE;
        held_next    = data_byte;
        seg_len_next = rlbe_pkg::LEN_W'(1);
      end
      MODE_SINGLE: begin
        if (data_byte == held) begin
          mode_next    = MODE_RUN;
          seg_len_next = rlbe_pkg::LEN_W'(2);
        end else begin
          // held byte already sits at wr_ptr; put the new one after it
          ram_waddr    = wr_ptr + rlbe_pkg::RING_AW'(1);
          commit       = 2'd2;
          mode_next    = MODE_LITERAL;
          seg_len_next = rlbe_pkg::LEN_W'(2);
          held_next    = data_byte;
        end
      end
      MODE_RUN: begin
        if (data_byte == held &&
            seg_len < rlbe_pkg::LEN_W'(rlbe_pkg::MAX_SEGMENT)) begin
          seg_len_next = seg_len + rlbe_pkg::LEN_W'(1);
        end else begin
          close        = 1'b1;
          mode_next    = MODE_SINGLE;
          held_next    = data_byte;
          seg_len_next = rlbe_pkg::LEN_W'(1);
        end
      end
      default: begin
        if (seg_len >= rlbe_pkg::LEN_W'(rlbe_pkg::MAX_SEGMENT) || data_byte == held) begin
          close        = 1'b1;
          mode_next    = MODE_SINGLE;
          held_next    = data_byte;
          seg_len_next = rlbe_pkg::LEN_W'(1);
        end else begin
          commit       = 2'd1;
          seg_len_next = seg_len + rlbe_pkg::LEN_W'(1);
          held_next    = data_byte;
        end
      end
    endcase
  end

  // Pick the segment to flush: the closed one, or the open one at block end
  always_comb begin
    if (close) begin
      flush_mode = mode;
      flush_val  = held;
      flush_len  = seg_len;
    end else begin
      flush_mode = mode_next;
      flush_val  = held_next;
      flush_len  = seg_len_next;
    end
    cmd.is_lit   = (flush_mode == MODE_LITERAL);
    cmd.hdr      = cmd.is_lit ? (8'(flush_len) - 8'd1) : (8'd1 - 8'(flush_len));
    cmd.val      = flush_val;
    cmd.lit_len  = flush_len;
    cmd.has_tail = close && block_last;
    cmd.tail_val = data_byte;
    cmd.blk_last = block_last;
    cmd_push     = accept && (close || block_last);
  end

  // Hold segment state; advance ring write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      held    <= 8'd0;
      seg_len <= '0;
      wr_ptr  <= '0;
      fill    <= '0;
    end else begin
      if (accept) begin
        held   <= held_next;
        wr_ptr <= wr_ptr + rlbe_pkg::RING_AW'(commit);
        if (block_last) begin
          mode    <= MODE_IDLE;
          seg_len <= '0;
        end else begin
          mode    <= mode_next;
          seg_len <= seg_len_next;
        end
      end
      fill <= fill + rlbe_pkg::FILL_W'(accept ? commit : 2'd0)
                   - rlbe_pkg::FILL_W'(lit_read);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rlbe_fifo.sv =====
`default_nettype none

module rlbe_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire rlbe_pkg::cmd_t  din,
  output logic                 q_full,
  input  wire logic            rd,
  output rlbe_pkg::cmd_t       dout,
  output logic                 q_empty
);

  rlbe_pkg::cmd_t              entries [rlbe_pkg::QDEPTH];
  logic [rlbe_pkg::QAW-1:0]    wp;
  logic [rlbe_pkg::QAW-1:0]    rp;
  logic [rlbe_pkg::QCW-1:0]    count;
  logic                        do_wr;
  logic                        do_rd;

  assign q_full  = (count == rlbe_pkg::QCW'(rlbe_pkg::QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign dout    = entries[rp];

  // Store commands in arrival order
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wp] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == rlbe_pkg::QAW'(rlbe_pkg::QDEPTH - 1)) ? '0 : wp + rlbe_pkg::QAW'(1);
      end
      if (do_rd) begin
        rp <= (rp == rlbe_pkg::QAW'(rlbe_pkg::QDEPTH - 1)) ? '0 : rp + rlbe_pkg::QAW'(1);
      end
      count <= count + rlbe_pkg::QCW'(do_wr) - rlbe_pkg::QCW'(do_rd);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rlbe_back.sv =====
`default_nettype none

module rlbe_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_empty,
  input  wire rlbe_pkg::cmd_t               q_dout,
  output logic                              q_pop,
  output logic                              ram_re,
  output logic [rlbe_pkg::RING_AW-1:0]      ram_raddr,
  input  wire logic [7:0]                   ram_rdata,
  output logic                              lit_read,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [7:0]                        out_byte0,
  output logic [7:0]                        out_byte1,
  output logic [7:0]                        out_byte2,
  output logic [7:0]                        out_byte3,
  output logic [rlbe_pkg::CNT_W-1:0]        out_count,
  output logic                              burst_end,
  output logic                              block_end
);

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_BODY,
    PH_TAIL_HEAD,
    PH_TAIL_VAL
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic       from_ram;
    logic [7:0] imm;
    logic       step_end;
    logic       blk_end;
  } token_t;

  phase_t                         phase;
  logic                           busy;
  rlbe_pkg::cmd_t                 cur;
  logic [rlbe_pkg::LEN_W-1:0]     remaining;
  logic [rlbe_pkg::RING_AW-1:0]   rd_ptr;
  token_t                         t1;
  logic [7:0]                     part [rlbe_pkg::OUT_SLOTS];
  logic [rlbe_pkg::CNT_W-1:0]     pcount;
  logic                           out_valid;
  logic [7:0]                     obytes [rlbe_pkg::OUT_SLOTS];

  logic                           out_free;
  logic                           t1_take;
  logic                           issue;
  logic                           load;
  logic                           tok_ram;
  logic [7:0]                     tok_imm;
  logic                           tok_finish;
  logic [7:0]                     byte_in;
  logic [7:0]                     part_w [rlbe_pkg::OUT_SLOTS];
  logic [rlbe_pkg::CNT_W-1:0]     pcount_inc;
  logic                           word_done;

  assign empty     = !out_valid;
  assign out_byte0 = obytes[0];
  assign out_byte1 = obytes[1];
  assign out_byte2 = obytes[2];
  assign out_byte3 = obytes[3];

  // Handshake between generator, read stage and packer
  assign out_free = !out_valid || pop;
  assign t1_take  = t1.valid && out_free;
  assign issue    = busy && (!t1.valid || t1_take);

  // Byte produced by the current phase
  always_comb begin
    tok_ram    = 1'b0;
    tok_imm    = 8'd0;
    tok_finish = 1'b0;
    case (phase)
      PH_HEAD: begin
        tok_imm = cur.hdr;
      end
      PH_BODY: begin
        tok_ram    = cur.is_lit;
        tok_imm    = cur.val;
        tok_finish = (remaining == rlbe_pkg::LEN_W'(1)) && !cur.has_tail;
      end
      PH_TAIL_HEAD: begin
        tok_imm = 8'd0;
      end
      PH_TAIL_VAL: begin
        tok_imm    = cur.tail_val;
        tok_finish = 1'b1;
      end
      default: begin
        tok_imm = 8'd0;
      end
    endcase
  end

  assign load      = !q_empty && (!busy || (issue && tok_finish));
  assign q_pop     = load;
  assign ram_re    = issue && tok_ram;
  assign ram_raddr = rd_ptr;
  assign lit_read  = ram_re;

  // Insert the arriving byte into the partial word
  assign byte_in    = t1.from_ram ? ram_rdata : t1.imm;
  assign pcount_inc = pcount + rlbe_pkg::CNT_W'(1);
  assign word_done  = (pcount_inc == rlbe_pkg::CNT_W'(rlbe_pkg::PACK_WIDTH)) || t1.step_end;

  always_comb begin
    for (int i = 0; i < rlbe_pkg::OUT_SLOTS; i++) begin
      part_w[i] = part[i];
    end
    part_w[pcount[rlbe_pkg::SLOT_AW-1:0]] = byte_in;
  end

  // Sequence commands, hold the read stage, pack bytes into results
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_HEAD;
      remaining <= '0;
      rd_ptr    <= '0;
      t1        <= '0;
      pcount    <= '0;
      out_valid <= 1'b0;
      out_count <= '0;
      burst_end <= 1'b0;
      block_end <= 1'b0;
      for (int i = 0; i < rlbe_pkg::OUT_SLOTS; i++) begin
        part[i]   <= 8'd0;
        obytes[i] <= 8'd0;
      end
    end else begin
      // take the next command, or advance the phase of the current one
      if (load) begin
        cur   <= q_dout;
        busy  <= 1'b1;
        phase <= PH_HEAD;
      end else if (issue) begin
        case (phase)
          PH_HEAD: begin
            phase     <= PH_BODY;
            remaining <= cur.is_lit ? cur.lit_len : rlbe_pkg::LEN_W'(1);
          end
          PH_BODY: begin
            remaining <= remaining - rlbe_pkg::LEN_W'(1);
            if (remaining == rlbe_pkg::LEN_W'(1)) begin
              if (cur.has_tail) begin
                phase <= PH_TAIL_HEAD;
              end else begin
                busy <= 1'b0;
              end
            end
          end
          PH_TAIL_HEAD: begin
            phase <= PH_TAIL_VAL;
          end
          PH_TAIL_VAL: begin
            busy <= 1'b0;
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
      if (ram_re) begin
        rd_ptr <= rd_ptr + rlbe_pkg::RING_AW'(1);
      end

      // read stage: one byte in flight, aligned with the RAM read data
      if (issue) begin
        t1.valid    <= 1'b1;
        t1.from_ram <= tok_ram;
        t1.imm      <= tok_imm;
        t1.step_end <= tok_finish;
        t1.blk_end  <= tok_finish && cur.blk_last;
      end else if (t1_take) begin
        t1.valid <= 1'b0;
      end

      // packer and output register
      if (t1_take && word_done) begin
        out_valid <= 1'b1;
        out_count <= pcount_inc;
        burst_end <= t1.step_end;
        block_end <= t1.blk_end;
        pcount    <= '0;
        for (int i = 0; i < rlbe_pkg::OUT_SLOTS; i++) begin
          obytes[i] <= part_w[i];
          part[i]   <= 8'd0;
        end
      end else begin
        if (pop && out_valid) begin
          out_valid <= 1'b0;
        end
        if (t1_take) begin
          pcount <= pcount_inc;
          for (int i = 0; i < rlbe_pkg::OUT_SLOTS; i++) begin
            part[i] <= part_w[i];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/run_length_byte_encoder.sv =====
// Run-length byte encoder: one input byte per cycle while the command queue and literal ring
// have room; the back end produces one compressed byte per cycle while commands are queued and
// the receiver keeps up, packed up to four to a result (a command's last byte ends its result);
// a receiver that holds off stalls the back end.
// Reset (rst, synchronous, active high) empties queues and returns to idle.
`default_nettype none

module run_length_byte_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        block_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte0,
  output logic [7:0]       out_byte1,
  output logic [7:0]       out_byte2,
  output logic [7:0]       out_byte3,
  output logic [2:0]       out_count,
  output logic             burst_end,
  output logic             block_end
);

  rlbe_pkg::cmd_t                  f_cmd;
  rlbe_pkg::cmd_t                  q_dout;
  logic                            f_push;
  logic                            q_full;
  logic                            q_empty;
  logic                            q_pop;
  logic                            lit_read;
  logic                            ram_we;
  logic [rlbe_pkg::RING_AW-1:0]    ram_waddr;
  logic [7:0]                      ram_wdata;
  logic                            ram_re;
  logic [rlbe_pkg::RING_AW-1:0]    ram_raddr;
  logic [7:0]                      ram_rdata;

  rlbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .block_last (block_last),
    .q_full     (q_full),
    .cmd_push   (f_push),
    .cmd        (f_cmd),
    .lit_read   (lit_read),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  rlbe_ram #(
    .WIDTH (8),
    .DEPTH (rlbe_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rlbe_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .din     (f_cmd),
    .q_full  (q_full),
    .rd      (q_pop),
    .dout    (q_dout),
    .q_empty (q_empty)
  );

  rlbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .lit_read  (lit_read),
    .empty     (empty),
    .pop       (pop),
    .out_byte0 (out_byte0),
    .out_byte1 (out_byte1),
    .out_byte2 (out_byte2),
    .out_byte3 (out_byte3),
    .out_count (out_count),
    .burst_end (burst_end),
    .block_end (block_end)
  );

endmodule

`default_nettype wire
